FILE: src/osrch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osrch_pkg
// Shared types and constants of the 1-Wire ROM search decision core.
// ----------------------------------------------------------------------------
package osrch_pkg;

	// Bus event codes carried in the command field.
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_PAIR  = 2'd2;

	// Configuration register indexes.
	localparam logic [7:0] REG_SEARCH_CODE = 8'd0;
	localparam logic [7:0] REG_MAX_IDS     = 8'd1;

	// Reset values of the configuration registers.
	localparam logic [7:0] SEARCH_CODE_RESET = 8'hF0;
	localparam logic [7:0] MAX_IDS_RESET     = 8'd8;

	// Reflected Dallas CRC-8 polynomial.
	localparam logic [7:0] CRC_POLY = 8'h8C;

	typedef enum logic [2:0] {
		ST_CONTINUE   = 3'd0,
		ST_ID_READY   = 3'd1,
		ST_NO_DEVICES = 3'd2,
		ST_BUS_ERROR  = 3'd3,
		ST_CRC_ERROR  = 3'd4,
		ST_OUT_OF_SEQ = 3'd5
	} osrch_status_t;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_AWAIT_RESET = 2'd1,
		PH_BITS       = 2'd2
	} osrch_phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic       presence;
		logic       id_bit;
		logic       complement_bit;
	} osrch_item_t;

	typedef struct packed {
		logic [7:0]    tx_byte;
		logic          write_bit;
		osrch_status_t status;
		logic [63:0]   rom_id;
		logic          enumeration_done;
	} osrch_result_t;

	typedef struct packed {
		logic [7:0] search_code;
		logic [7:0] max_ids;
	} osrch_cfg_t;

	// One step of the reflected CRC-8 for a single data bit.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic din);
		logic [7:0] shifted;
		shifted = {1'b0, crc[7:1]};
		return (crc[0] ^ din) ? (shifted ^ CRC_POLY) : shifted;
	endfunction

endpackage
`default_nettype wire

FILE: src/osrch_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osrch_core
// Search state and the combinational decision for one bus event: phase
// control, fork rule, ROM id assembly, running CRC-8 and id counting.
// ----------------------------------------------------------------------------
module osrch_core #(
	parameter int ROM_BITS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     fire,
	input  osrch_pkg::osrch_item_t  item,
	input  osrch_pkg::osrch_cfg_t   cfg,
	output osrch_pkg::osrch_result_t result
);
	import osrch_pkg::*;

	localparam int PW = $clog2(ROM_BITS);
	localparam logic [PW:0]   FORK_NONE = (PW + 1)'(ROM_BITS);
	localparam logic [PW-1:0] LAST_POS  = PW'(ROM_BITS - 1);

	osrch_phase_t        phase_q, phase_nxt;
	logic [ROM_BITS-1:0] rom_shift_q, rom_shift_nxt;
	logic [PW-1:0]       bit_pos_q, bit_pos_nxt;
	logic [PW:0]         prev_fork_q, prev_fork_nxt;
	logic [PW:0]         pass_fork_q, pass_fork_nxt;
	logic [7:0]          crc_q, crc_nxt;
	logic [7:0]          ids_q, ids_nxt;
	logic                first_pass_q, first_pass_nxt;

	// Direction decision for the current bit position.
	logic                pair_fork;
	logic                dir;
	logic [ROM_BITS-1:0] rom_written;
	logic [7:0]          crc_stepped;
	logic [7:0]          ids_inc;
	logic [PW:0]         pass_fork_upd;
	logic                last_bit;

	assign pair_fork = !item.id_bit && !item.complement_bit;

	always_comb begin
		if (item.id_bit != item.complement_bit) begin
			dir = item.id_bit;
		end else if ({1'b0, bit_pos_q} < prev_fork_q) begin
			dir = rom_shift_q[bit_pos_q];
		end else begin
			dir = ({1'b0, bit_pos_q} == prev_fork_q);
		end
	end

	assign rom_written   = (rom_shift_q & ~(ROM_BITS'(1) << bit_pos_q))
	                     | (ROM_BITS'(dir) << bit_pos_q);
	assign crc_stepped   = crc8_step(crc_q, dir);
	assign ids_inc       = (ids_q == 8'hFF) ? ids_q : ids_q + 8'd1;
	assign pass_fork_upd = (pair_fork && !dir) ? {1'b0, bit_pos_q} : pass_fork_q;
	assign last_bit      = (bit_pos_q == LAST_POS);

	// Next state and result for the event at the head of the input register.
	always_comb begin
		phase_nxt      = phase_q;
		rom_shift_nxt  = rom_shift_q;
		bit_pos_nxt    = bit_pos_q;
		prev_fork_nxt  = prev_fork_q;
		pass_fork_nxt  = pass_fork_q;
		crc_nxt        = crc_q;
		ids_nxt        = ids_q;
		first_pass_nxt = first_pass_q;
		result         = '0;
		result.status  = ST_CONTINUE;

		unique case (item.command)
			CMD_BEGIN: begin
				rom_shift_nxt  = '0;
				bit_pos_nxt    = '0;
				prev_fork_nxt  = FORK_NONE;
				pass_fork_nxt  = FORK_NONE;
				crc_nxt        = '0;
				ids_nxt        = '0;
				first_pass_nxt = 1'b1;
				phase_nxt      = PH_AWAIT_RESET;
			end
			CMD_RESET: begin
				if (phase_q != PH_AWAIT_RESET) begin
					result.status = ST_OUT_OF_SEQ;
				end else if (item.presence) begin
					result.tx_byte = cfg.search_code;
					bit_pos_nxt    = '0;
					pass_fork_nxt  = FORK_NONE;
					crc_nxt        = '0;
					phase_nxt      = PH_BITS;
				end else begin
					result.status = first_pass_q ? ST_NO_DEVICES : ST_BUS_ERROR;
					phase_nxt     = PH_IDLE;
				end
			end
			CMD_PAIR: begin
				if (phase_q != PH_BITS) begin
					result.status = ST_OUT_OF_SEQ;
				end else if (item.id_bit && item.complement_bit) begin
					// Nobody answered the slot pair.
					result.status = (bit_pos_q == '0 && first_pass_q) ?
					                ST_NO_DEVICES : ST_BUS_ERROR;
					phase_nxt     = PH_IDLE;
				end else begin
					rom_shift_nxt    = rom_written;
					crc_nxt          = crc_stepped;
					pass_fork_nxt    = pass_fork_upd;
					result.write_bit = dir;
					if (!last_bit) begin
						bit_pos_nxt = bit_pos_q + PW'(1);
					end else begin
						bit_pos_nxt = '0;
						if (crc_stepped != 8'h00) begin
							result.status = ST_CRC_ERROR;
							phase_nxt     = PH_IDLE;
						end else begin
							result.status  = ST_ID_READY;
							result.rom_id  = 64'(rom_written);
							ids_nxt        = ids_inc;
							first_pass_nxt = 1'b0;
							if (pass_fork_upd == FORK_NONE || ids_inc >= cfg.max_ids) begin
								result.enumeration_done = 1'b1;
								phase_nxt               = PH_IDLE;
							end else begin
								prev_fork_nxt = pass_fork_upd;
								phase_nxt     = PH_AWAIT_RESET;
							end
						end
					end
				end
			end
			default: begin
				result.status = ST_OUT_OF_SEQ;
			end
		endcase
	end

	// State registers, updated as each event leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			rom_shift_q  <= '0;
			bit_pos_q    <= '0;
			prev_fork_q  <= FORK_NONE;
			pass_fork_q  <= FORK_NONE;
			crc_q        <= '0;
			ids_q        <= '0;
			first_pass_q <= 1'b1;
		end else if (fire) begin
			phase_q      <= phase_nxt;
			rom_shift_q  <= rom_shift_nxt;
			bit_pos_q    <= bit_pos_nxt;
			prev_fork_q  <= prev_fork_nxt;
			pass_fork_q  <= pass_fork_nxt;
			crc_q        <= crc_nxt;
			ids_q        <= ids_nxt;
			first_pass_q <= first_pass_nxt;
		end
	end

	// An out-of-sequence event leaves the search state untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.status == ST_OUT_OF_SEQ |=>
			$stable(phase_q) && $stable(rom_shift_q) && $stable(ids_q))
		else $error("out-of-sequence event changed the search state");

	// Every terminal error outcome (no devices, bus or CRC error) and the end of enumeration return the block to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (result.status == ST_NO_DEVICES || result.status == ST_BUS_ERROR ||
		         result.status == ST_CRC_ERROR || result.enumeration_done) |=>
			phase_q == PH_IDLE)
		else $error("search did not return to idle after a terminal outcome");

	// A completed id always comes back to position zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.status == ST_ID_READY |=> bit_pos_q == '0 && !first_pass_q)
		else $error("bit position not rewound after a reported id");

endmodule
`default_nettype wire

FILE: src/onewire_rom_search_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// Decision core of a 1-Wire ROM enumeration: one result per bus event.
// ----------------------------------------------------------------------------
// Each transferred bus event (begin, reset outcome or id/complement bit pair)
// yields exactly one result carrying the byte or direction bit to put on the
// bus and a status code. Events are taken at one per clock cycle unless the
// output stalls: an event is held in the input register until the output
// register is free or being emptied, while the decision logic of the search
// core works out its result and the new search state, and the result is then
// held in the output register until it is transferred. The output register
// lets a new event enter while an earlier result still waits; only a held
// result with the input register also full stops further transfers.
// Configuration writes are always accepted and take effect at the next edge.
module onewire_rom_search_engine #(
	parameter int ROM_BITS = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      item_valid,
	output logic                     item_ready,
	input  osrch_pkg::osrch_item_t   item,
	output logic                     result_valid,
	input  wire                      result_ready,
	output osrch_pkg::osrch_result_t result,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [7:0]               cfg_index,
	input  wire  [7:0]               cfg_data
);
	import osrch_pkg::*;

	osrch_cfg_t    cfg_q;
	osrch_item_t   item_s1;
	logic          valid_s1;
	osrch_result_t result_s2;
	logic          valid_s2;
	osrch_result_t decided;
	logic          advance;

	// An event moves on when the output register is free or being emptied.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.search_code <= SEARCH_CODE_RESET;
			cfg_q.max_ids     <= MAX_IDS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SEARCH_CODE) begin
				cfg_q.search_code <= cfg_data;
			end
			if (cfg_index == REG_MAX_IDS) begin
				cfg_q.max_ids <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	osrch_core #(
		.ROM_BITS (ROM_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (decided)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= decided;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// An accepted event always occupies the input register next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> valid_s1)
		else $error("accepted event lost from the input register");

	// Each event that leaves the input register shows up as a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("decided event produced no result");

	// A held result with a full input register blocks new transfers.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ready |-> !item_ready)
		else $error("input accepted while both registers are full");

endmodule
`default_nettype wire
